// File: rtl/button_debounce_long_press_repeat_macros.svh
// Assertion macros used by the checker file.
`ifndef BUTTON_DEBOUNCE_LONG_PRESS_REPEAT_MACROS_SVH
`define BUTTON_DEBOUNCE_LONG_PRESS_REPEAT_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define BDLPR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off while reset is asserted.
`define BDLPR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/bdlpr_pkg.sv
`timescale 1ns / 1ps

package bdlpr_pkg;

    localparam int unsigned TIME_W    = 32;
    localparam int unsigned KEY_W     = 8;
    localparam int unsigned CFG_W     = 32;
    localparam int unsigned CFG_NUM   = 4;
    localparam int unsigned CFG_IDX_W = $clog2(CFG_NUM);

    localparam logic [TIME_W-1:0] DEBOUNCE_RST   = 32'd20000;
    localparam logic [TIME_W-1:0] LONG_PRESS_RST = 32'd1000000;
    localparam logic [TIME_W-1:0] REPEAT_RST     = 32'd200000;
    localparam logic [KEY_W-1:0]  KEY_CODE_RST   = 8'd0;

    // kind field: key seen down on a scan, or scan timer elapsed
    localparam logic KIND_PRESSED = 1'b0;
    localparam logic KIND_ELAPSED = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE     = 4'd0,
        ST_PROBABLE = 4'd1,
        ST_P_BREAK  = 4'd2,
        ST_P_MAKE   = 4'd3,
        ST_PRESSED  = 4'd4,
        ST_LONG     = 4'd5,
        ST_R_BREAK  = 4'd6,
        ST_R_MAKE   = 4'd7,
        ST_RELEASED = 4'd8
    } key_state_t;

    typedef enum logic [1:0] {
        EV_PRESSED  = 2'd0,
        EV_LONG     = 2'd1,
        EV_REPEAT   = 2'd2,
        EV_RELEASED = 2'd3
    } key_event_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE   = 2'd0,
        CFG_LONG_PRESS = 2'd1,
        CFG_REPEAT     = 2'd2,
        CFG_KEY_CODE   = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [TIME_W-1:0] debounce_time;
        logic [TIME_W-1:0] long_press_time;
        logic [TIME_W-1:0] repeat_time;
    } timing_cfg_t;

    typedef struct packed {
        logic              fire;
        key_event_t        key_event;
        logic [TIME_W-1:0] event_time;
    } step_result_t;

endpackage

// File: rtl/bdlpr_in_if.sv
`timescale 1ns / 1ps

interface bdlpr_in_if;
    import bdlpr_pkg::*;

    logic              valid;
    logic              ready;
    logic              kind;
    logic [TIME_W-1:0] now_time;

    modport source (output valid, output kind, output now_time, input ready);
    modport sink   (input valid, input kind, input now_time, output ready);
endinterface

// File: rtl/bdlpr_out_if.sv
`timescale 1ns / 1ps

interface bdlpr_out_if;
    import bdlpr_pkg::*;

    logic              valid;
    logic              ready;
    logic [1:0]        key_event;
    logic [TIME_W-1:0] event_time;
    logic [KEY_W-1:0]  key_id;

    modport source (output valid, output key_event, output event_time, output key_id,
                    input ready);
    modport sink   (input valid, input key_event, input event_time, input key_id,
                    output ready);
endinterface

// File: rtl/button_debounce_long_press_repeat.sv
`timescale 1ns / 1ps
// Path: a request's report passes through the input register, then the result
// register, before it shows on the report port; a stalled report side holds it.
// Throughput: one request per cycle while the report side keeps up; the single
// subtract-and-compare of the key state step sets the cycle. Requests that cause
// no event produce no result.
// Reset: rst_n clears to the released state, zero mark time and the default timings.
module button_debounce_long_press_repeat (
    input  logic                                clk,
    input  logic                                rst_n,
    bdlpr_in_if.sink                            scan,
    bdlpr_out_if.source                         report,
    input  logic                                write_en,
    input  logic [bdlpr_pkg::CFG_IDX_W-1:0]     reg_index,
    input  logic [bdlpr_pkg::CFG_W-1:0]         write_data
);
    import bdlpr_pkg::*;

    // configuration registers
    timing_cfg_t       timing_reg;
    logic [KEY_W-1:0]  key_code_reg;

    // input register
    logic              hold_valid_reg;
    logic              hold_kind_reg;
    logic [TIME_W-1:0] hold_time_reg;

    // result register
    logic              res_valid_reg;
    key_event_t        res_event_reg;
    logic [TIME_W-1:0] res_time_reg;
    logic [KEY_W-1:0]  res_key_reg;

    logic              res_free;
    logic              advance;
    logic              take;
    step_result_t      step_res;

    // The result register frees up when it is empty or being drained this cycle;
    // the held request moves on exactly then, so a new request can enter every
    // cycle while the report side keeps up.
    assign res_free   = !res_valid_reg || report.ready;
    assign advance    = hold_valid_reg && res_free;
    assign scan.ready = !hold_valid_reg || res_free;
    assign take       = scan.valid && scan.ready;

    // Configuration writes land directly; the user writes only while the block is idle (not enforced).
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timing_reg.debounce_time   <= DEBOUNCE_RST;
            timing_reg.long_press_time <= LONG_PRESS_RST;
            timing_reg.repeat_time     <= REPEAT_RST;
            key_code_reg               <= KEY_CODE_RST;
        end
        else if (write_en)
        begin
            case (cfg_index_t'(reg_index))
                CFG_DEBOUNCE:   timing_reg.debounce_time   <= write_data[TIME_W-1:0];
                CFG_LONG_PRESS: timing_reg.long_press_time <= write_data[TIME_W-1:0];
                CFG_REPEAT:     timing_reg.repeat_time     <= write_data[TIME_W-1:0];
                CFG_KEY_CODE:   key_code_reg               <= write_data[KEY_W-1:0];
                default:        key_code_reg               <= key_code_reg;
            endcase
        end
    end

    // Capture the request; hold it while the result register is stalled.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_valid_reg <= 1'b0;
        else if (scan.ready)
            hold_valid_reg <= scan.valid;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            hold_kind_reg <= scan.kind;
            hold_time_reg <= scan.now_time;
        end
    end

    // Key state machine: advances once per request leaving the input register.
    bdlpr_fsm u_fsm (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (advance),
        .kind     (hold_kind_reg),
        .now_time (hold_time_reg),
        .cfg      (timing_reg),
        .result   (step_res)
    );

    // Result register: load an event when one fires, drop the slot otherwise.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (res_free)
            res_valid_reg <= advance && step_res.fire;
    end

    always_ff @(posedge clk)
    begin
        if (advance && step_res.fire)
        begin
            res_event_reg <= step_res.key_event;
            res_time_reg  <= step_res.event_time;
            res_key_reg   <= key_code_reg;
        end
    end

    assign report.valid      = res_valid_reg;
    assign report.key_event  = res_event_reg;
    assign report.event_time = res_time_reg;
    assign report.key_id     = res_key_reg;

endmodule

// File: rtl/bdlpr_fsm.sv
`timescale 1ns / 1ps

module bdlpr_fsm (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                step,
    input  logic                                kind,
    input  logic [bdlpr_pkg::TIME_W-1:0]        now_time,
    input  bdlpr_pkg::timing_cfg_t              cfg,
    output bdlpr_pkg::step_result_t             result
);
    import bdlpr_pkg::*;

    key_state_t        state_reg, state_next;
    logic [TIME_W-1:0] mark_reg, mark_next;
    logic [TIME_W-1:0] elapsed;
    logic [TIME_W-1:0] limit;
    logic              pressed;
    logic              expired;

    assign pressed = (kind == KIND_PRESSED);
    // wrapping difference, so a rollover of now_time is harmless
    assign elapsed = now_time - mark_reg;

    always_comb
    begin
        case (state_reg)
            ST_P_MAKE:  limit = cfg.debounce_time;
            ST_PRESSED: limit = cfg.long_press_time;
            default:    limit = cfg.repeat_time;
        endcase
    end

    assign expired = (elapsed > limit);

    // next state and mark
    always_comb
    begin
        state_next = state_reg;
        mark_next  = mark_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (pressed)
                    state_next = ST_PROBABLE;
            end
            ST_PROBABLE:
            begin
                if (pressed)
                begin
                    state_next = ST_P_BREAK;
                    mark_next  = now_time;
                end
                else
                    state_next = ST_IDLE;
            end
            ST_P_BREAK:
            begin
                if (pressed)
                begin
                    state_next = ST_P_MAKE;
                    mark_next  = now_time;
                end
                else
                    state_next = ST_PROBABLE;
            end
            ST_P_MAKE:
            begin
                if (!pressed)
                    state_next = ST_P_BREAK;
                else if (expired)
                begin
                    state_next = ST_PRESSED;
                    mark_next  = now_time;
                end
            end
            ST_PRESSED:
            begin
                if (!pressed)
                    state_next = ST_R_BREAK;
                else if (expired)
                begin
                    state_next = ST_LONG;
                    mark_next  = now_time;
                end
            end
            ST_LONG:
            begin
                if (!pressed)
                    state_next = ST_R_BREAK;
                else if (expired)
                    mark_next = now_time;
            end
            ST_R_BREAK:
                state_next = pressed ? ST_LONG : ST_R_MAKE;
            ST_R_MAKE:
                state_next = pressed ? ST_P_BREAK : ST_RELEASED;
            default:
                state_next = pressed ? ST_PROBABLE : ST_RELEASED;
        endcase
    end

    // reported event
    always_comb
    begin
        result.fire       = 1'b0;
        result.key_event  = EV_PRESSED;
        result.event_time = now_time;
        case (state_reg)
            ST_P_MAKE:
                result.fire = pressed && expired;
            ST_PRESSED:
            begin
                result.fire      = pressed && expired;
                result.key_event = EV_LONG;
            end
            ST_LONG:
            begin
                result.fire      = pressed && expired;
                result.key_event = EV_REPEAT;
            end
            ST_R_MAKE:
            begin
                result.fire      = !pressed;
                result.key_event = EV_RELEASED;
            end
            default:
                result.fire = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RELEASED;
            mark_reg  <= '0;
        end
        else if (step)
        begin
            state_reg <= state_next;
            mark_reg  <= mark_next;
        end
    end

endmodule

// File: rtl/bdlpr_checker.sv
`timescale 1ns / 1ps
`include "button_debounce_long_press_repeat_macros.svh"

module bdlpr_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          scan_valid,
    input logic                          scan_ready,
    input logic                          report_valid,
    input logic                          report_ready,
    input logic [1:0]                    report_event,
    input logic [bdlpr_pkg::TIME_W-1:0]  report_time,
    input logic [bdlpr_pkg::KEY_W-1:0]   report_key
);
    import bdlpr_pkg::*;

    // a stalled result keeps its payload
    `BDLPR_ASSERT_NEXT(a_report_hold, clk, rst_n, report_valid && !report_ready,
        report_valid && $stable(report_event) && $stable(report_time) && $stable(report_key),
        "stalled result changed")

    // with no result pending the block must take a request
    `BDLPR_ASSERT_NOW(a_ready_when_empty, clk, rst_n, !report_valid, scan_ready,
        "request refused while result register empty")

    // a request accepted into a stalled block fills the input register: no more
    `BDLPR_ASSERT_NOW(a_backpressure, clk, rst_n,
        $past(report_valid && !report_ready) && $past(scan_valid && scan_ready)
            && report_valid && !report_ready,
        !scan_ready,
        "request taken while both stages are full")

endmodule

bind button_debounce_long_press_repeat bdlpr_checker u_bdlpr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .scan_valid   (scan.valid),
    .scan_ready   (scan.ready),
    .report_valid (report.valid),
    .report_ready (report.ready),
    .report_event (report.key_event),
    .report_time  (report.event_time),
    .report_key   (report.key_id)
);

// File: tb/tb_button_debounce_long_press_repeat.sv
`timescale 1ns / 1ps

module tb_button_debounce_long_press_repeat;
    import bdlpr_pkg::*;

    // Generous ceiling on the run length, well above the slowest correct run.
    localparam int unsigned LIMIT_CYCLES = 400000;
    // Two-stage pipeline, plus margin for requests that raise no report.
    localparam int unsigned DRAIN_CYCLES = 4;

    typedef struct {
        key_event_t        code;
        logic [TIME_W-1:0] stamp;
        logic [KEY_W-1:0]  id;
    } key_report_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 write_en;
    logic [CFG_IDX_W-1:0] reg_index;
    logic [CFG_W-1:0]     write_data;

    bdlpr_in_if  scan_if ();
    bdlpr_out_if report_if ();

    button_debounce_long_press_repeat u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .scan       (scan_if),
        .report     (report_if),
        .write_en   (write_en),
        .reg_index  (reg_index),
        .write_data (write_data)
    );

    always #5 clk = ~clk;

    // Shadow copy of the key qualifier: state, mark time and timing registers.
    key_state_t        cur_state;
    logic [TIME_W-1:0] mark_r;
    logic [TIME_W-1:0] debounce_r;
    logic [TIME_W-1:0] long_r;
    logic [TIME_W-1:0] repeat_r;
    logic [KEY_W-1:0]  key_r;

    // Reports the block still owes, oldest first.
    key_report_t       pending_reports[$];
    key_report_t       exp_rep;

    int                fail_count = 0;
    int                send_idle_pct = 0;
    int                recv_stall_pct = 0;
    logic [TIME_W-1:0] last_time = '0;
    int unsigned       cycle_count = 0;

    // Advance the shadow state by one accepted request; queue the report it raises.
    function automatic void qualify_key(input logic kind_in, input logic [TIME_W-1:0] now);
        logic [TIME_W-1:0] elapsed;
        logic              down;
        logic              fire;
        key_report_t       rep;
        elapsed  = now - mark_r;   // wraps modulo 2^32 by width
        down     = (kind_in == KIND_PRESSED);
        fire     = 1'b0;
        rep.code = EV_PRESSED;
        rep.stamp = now;
        rep.id   = key_r;
        case (cur_state)
            ST_IDLE:
                if (down) cur_state = ST_PROBABLE;
            ST_PROBABLE:
                if (down)
                begin
                    cur_state = ST_P_BREAK;
                    mark_r    = now;
                end
                else cur_state = ST_IDLE;
            ST_P_BREAK:
                if (down)
                begin
                    cur_state = ST_P_MAKE;
                    mark_r    = now;
                end
                else cur_state = ST_PROBABLE;
            ST_P_MAKE:
                if (!down) cur_state = ST_P_BREAK;
                else if (elapsed > debounce_r)
                begin
                    cur_state = ST_PRESSED;
                    mark_r    = now;
                    fire      = 1'b1;
                    rep.code  = EV_PRESSED;
                end
            ST_PRESSED:
                if (!down) cur_state = ST_R_BREAK;
                else if (elapsed > long_r)
                begin
                    cur_state = ST_LONG;
                    mark_r    = now;
                    fire      = 1'b1;
                    rep.code  = EV_LONG;
                end
            ST_LONG:
                if (!down) cur_state = ST_R_BREAK;
                else if (elapsed > repeat_r)
                begin
                    mark_r   = now;
                    fire     = 1'b1;
                    rep.code = EV_REPEAT;
                end
            ST_R_BREAK:
                // An elapsed scan here moves on toward release.
                if (down) cur_state = ST_LONG;
                else cur_state = ST_R_MAKE;
            ST_R_MAKE:
                if (down) cur_state = ST_P_BREAK;
                else
                begin
                    cur_state = ST_RELEASED;
                    fire      = 1'b1;
                    rep.code  = EV_RELEASED;
                end
            default:
                // Released, and any stray code, acts as released.
                if (down) cur_state = ST_PROBABLE;
                else cur_state = ST_RELEASED;
        endcase
        if (fire) pending_reports.push_back(rep);
    endfunction

    // Choose the next scan kind: mostly a well-formed press and release, some noise.
    function automatic logic pick_kind();
        int roll;
        roll = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < 15) return logic'($urandom_range(0, 1));
        case (cur_state)
            ST_R_BREAK, ST_R_MAKE: return (roll < 80) ? KIND_ELAPSED : KIND_PRESSED;
            ST_LONG:               return (roll < 25) ? KIND_ELAPSED : KIND_PRESSED;
            ST_PRESSED:            return (roll < 15) ? KIND_ELAPSED : KIND_PRESSED;
            default:               return (roll < 10) ? KIND_ELAPSED : KIND_PRESSED;
        endcase
    endfunction

    // Choose a timestamp, mostly placed right around the threshold that matters now.
    function automatic logic [TIME_W-1:0] pick_time();
        logic [TIME_W-1:0] thr;
        int                sel;
        case (cur_state)
            ST_P_MAKE:  thr = debounce_r;
            ST_PRESSED: thr = long_r;
            ST_LONG:    thr = repeat_r;
            default:    thr = $urandom_range(0, 50);
        endcase
        sel = $urandom_range(0, 99);
        if (sel < 15)      return $urandom;
        else if (sel < 30) return last_time + $urandom_range(0, 3);
        else if (sel < 45) return mark_r + thr;
        else if (sel < 65) return mark_r + thr + 1;
        else if (sel < 80) return mark_r + thr + $urandom_range(2, 20);
        else               return mark_r + (thr >> $urandom_range(0, 4));
    endfunction

    // Predict on every request the block takes.
    always @(posedge clk)
    begin
        if (rst_n && scan_if.valid && scan_if.ready)
            qualify_key(scan_if.kind, scan_if.now_time);
    end

    // Compare every report against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && report_if.valid && report_if.ready)
        begin
            if (pending_reports.size() == 0)
            begin
                $display("%0t: unexpected report: expected none, actual event %0d time %0d id %0d",
                         $time, report_if.key_event, report_if.event_time, report_if.key_id);
                fail_count++;
            end
            else
            begin
                exp_rep = pending_reports.pop_front();
                if (report_if.key_event !== exp_rep.code)
                begin
                    $display("%0t: key_event mismatch: expected %0d actual %0d",
                             $time, exp_rep.code, report_if.key_event);
                    fail_count++;
                end
                if (report_if.event_time !== exp_rep.stamp)
                begin
                    $display("%0t: event_time mismatch: expected %0d actual %0d",
                             $time, exp_rep.stamp, report_if.event_time);
                    fail_count++;
                end
                if (report_if.key_id !== exp_rep.id)
                begin
                    $display("%0t: key_id mismatch: expected %0d actual %0d",
                             $time, exp_rep.id, report_if.key_id);
                    fail_count++;
                end
            end
        end
    end

    // Drop ready at random on the report side, at the rate of the current phase.
    always @(negedge clk)
    begin
        report_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Stop a hung run.
    initial
    begin
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("button_debounce_long_press_repeat verification failed");
        $finish;
    end

    // Hold one request until it is taken; call right after a falling edge.
    // Valid stays high on return so back-to-back requests keep it up.
    task automatic drive_scan(input logic kind_in, input logic [TIME_W-1:0] now);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            scan_if.valid <= 1'b0;
            @(negedge clk);
        end
        scan_if.valid    <= 1'b1;
        scan_if.kind     <= kind_in;
        scan_if.now_time <= now;
        last_time = now;
        do @(posedge clk); while (!scan_if.ready);
    endtask

    task automatic send_scan(input logic kind_in, input logic [TIME_W-1:0] now);
        @(negedge clk);
        drive_scan(kind_in, now);
    endtask

    // Write one register and mirror it into the shadow copy.
    task automatic write_reg(input cfg_index_t idx, input logic [CFG_W-1:0] data);
        @(negedge clk);
        write_en   <= 1'b1;
        reg_index  <= idx;
        write_data <= data;
        @(negedge clk);
        write_en   <= 1'b0;
        case (idx)
            CFG_DEBOUNCE:   debounce_r = data;
            CFG_LONG_PRESS: long_r     = data;
            CFG_REPEAT:     repeat_r   = data;
            CFG_KEY_CODE:   key_r      = data[KEY_W-1:0];
            default:        ;
        endcase
    endtask

    task automatic set_timing(input logic [CFG_W-1:0] deb, input logic [CFG_W-1:0] lng,
                              input logic [CFG_W-1:0] rpt, input logic [CFG_W-1:0] key);
        write_reg(CFG_DEBOUNCE, deb);
        write_reg(CFG_LONG_PRESS, lng);
        write_reg(CFG_REPEAT, rpt);
        write_reg(CFG_KEY_CODE, key);
    endtask

    // Drop valid, wait for every owed report, then let the pipeline empty.
    task automatic settle_block();
        @(negedge clk);
        scan_if.valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Walk the whole state graph with the reset timings, hitting each
    // threshold exactly and one past it.
    task automatic test_default_walk();
        send_idle_pct  = 30;
        recv_stall_pct = 30;
        send_scan(KIND_ELAPSED, 32'hFFFF_FFFF);   // elapsed while released: ignored
        send_scan(KIND_PRESSED, 32'd0);
        send_scan(KIND_ELAPSED, 32'd5);           // probable falls back to idle
        send_scan(KIND_ELAPSED, 32'd6);           // elapsed while idle: ignored
        send_scan(KIND_PRESSED, 32'd10);
        send_scan(KIND_PRESSED, 32'd100);
        send_scan(KIND_ELAPSED, 32'd110);         // bounce break back to probable
        send_scan(KIND_PRESSED, 32'd120);
        send_scan(KIND_PRESSED, 32'd200);
        send_scan(KIND_ELAPSED, 32'd210);         // bounce make back to break
        send_scan(KIND_PRESSED, 32'd220);
        send_scan(KIND_PRESSED, 32'd20220);       // exactly debounce: no report
        send_scan(KIND_PRESSED, 32'd20221);       // pressed
        send_scan(KIND_PRESSED, 32'd1020221);     // exactly long press: no report
        send_scan(KIND_PRESSED, 32'd1020222);     // long press
        send_scan(KIND_PRESSED, 32'd1220222);
        send_scan(KIND_PRESSED, 32'd1220223);     // repeat
        send_scan(KIND_ELAPSED, 32'd1220300);
        send_scan(KIND_PRESSED, 32'd1220310);     // release break returns to long
        send_scan(KIND_ELAPSED, 32'd1220320);
        send_scan(KIND_ELAPSED, 32'd1220330);     // release break on to release make
        send_scan(KIND_PRESSED, 32'd1220340);     // release make back to press break
        send_scan(KIND_PRESSED, 32'd1220350);
        send_scan(KIND_PRESSED, 32'd1240351);     // pressed again
        send_scan(KIND_ELAPSED, 32'd1240360);
        send_scan(KIND_ELAPSED, 32'd1240370);
        send_scan(KIND_ELAPSED, 32'd1240380);     // released
    endtask

    // Zero and full-scale timings, with the timestamp wrapping mid-press.
    task automatic test_timing_extremes();
        settle_block();
        set_timing(32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF);
        send_scan(KIND_PRESSED, 32'hFFFF_FFF0);
        send_scan(KIND_PRESSED, 32'hFFFF_FFF8);
        send_scan(KIND_PRESSED, 32'hFFFF_FFFC);
        send_scan(KIND_PRESSED, 32'hFFFF_FFFC);   // zero elapsed is not past zero
        send_scan(KIND_PRESSED, 32'h0000_0002);   // wrapped, still pressed
        send_scan(KIND_PRESSED, 32'h0000_0003);
        send_scan(KIND_PRESSED, 32'h0000_0003);
        send_scan(KIND_PRESSED, 32'h0000_0004);
        send_scan(KIND_ELAPSED, 32'h0000_0005);
        send_scan(KIND_ELAPSED, 32'h0000_0006);
        send_scan(KIND_ELAPSED, 32'h0000_0007);
        settle_block();
        // Full-scale thresholds can never be passed: the key sticks in bounce make.
        set_timing(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_FF00);
        send_scan(KIND_PRESSED, 32'h0000_0000);
        send_scan(KIND_PRESSED, 32'h8000_0000);
        send_scan(KIND_PRESSED, 32'h8000_0001);
        send_scan(KIND_PRESSED, 32'h8000_0000);
        send_scan(KIND_ELAPSED, 32'h8000_0002);
        send_scan(KIND_ELAPSED, 32'h8000_0003);
        send_scan(KIND_ELAPSED, 32'h8000_0004);
    endtask

    // Random press episodes under one idling profile and one timing setting.
    task automatic test_random_traffic(input int unsigned n_items, input int send_pct,
                                       input int recv_pct, input bit wide_timing);
        logic              kind_n;
        logic [TIME_W-1:0] now_n;
        int unsigned       done;
        settle_block();
        if (wide_timing)
            set_timing($urandom, $urandom, $urandom, $urandom);
        else
            set_timing($urandom_range(0, 40), $urandom_range(0, 120),
                       $urandom_range(0, 40), $urandom);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        done = 0;
        while (done < n_items)
        begin
            // Pick after the falling edge so the shadow state holds the last request.
            @(negedge clk);
            kind_n = pick_kind();
            now_n  = pick_time();
            // Elapsed scans while idle or released do nothing: leave them uncounted.
            if (!(kind_n == KIND_ELAPSED && (cur_state == ST_IDLE || cur_state == ST_RELEASED)))
                done++;
            drive_scan(kind_n, now_n);
        end
    endtask

    initial
    begin
        rst_n              = 1'b0;
        write_en           = 1'b0;
        reg_index          = CFG_DEBOUNCE;
        write_data         = '0;
        scan_if.valid      = 1'b0;
        scan_if.kind       = KIND_PRESSED;
        scan_if.now_time   = '0;
        report_if.ready    = 1'b0;
        cur_state          = ST_RELEASED;
        mark_r             = '0;
        debounce_r         = DEBOUNCE_RST;
        long_r             = LONG_PRESS_RST;
        repeat_r           = REPEAT_RST;
        key_r              = KEY_CODE_RST;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_default_walk();
        test_timing_extremes();
        test_random_traffic(175, 0, 0, 1'b0);
        test_random_traffic(175, 85, 0, 1'b0);
        test_random_traffic(175, 0, 85, 1'b1);
        test_random_traffic(175, 22, 22, 1'b0);
        settle_block();

        if (fail_count == 0)
            $display("button_debounce_long_press_repeat verification clean");
        else
            $display("button_debounce_long_press_repeat verification failed");
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/bdlpr_pkg.sv
rtl/bdlpr_in_if.sv
rtl/bdlpr_out_if.sv
rtl/bdlpr_fsm.sv
rtl/button_debounce_long_press_repeat.sv
rtl/bdlpr_checker.sv
tb/tb_button_debounce_long_press_repeat.sv
